FILE: sv/token_bucket_acquire_timeout_assert.svh
`ifndef TOKEN_BUCKET_ACQUIRE_TIMEOUT_ASSERT_SVH
`define TOKEN_BUCKET_ACQUIRE_TIMEOUT_ASSERT_SVH

// concurrent check on an explicit clock and reset
`define TBA_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on the block clock and reset
`define TBA_ASSERT(label, prop, msg) \
   `TBA_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

FILE: sv/tba_pkg.sv
`timescale 1ns / 1ps

package tba_pkg;

   localparam int COUNT_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int CFG_W     = 32;
   localparam int WANT_W    = 16;
   localparam int WAIT_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] FILL_RESET    = 32'd65536;
   localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_FILL_PER_TICK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'd1;

   // two-entry queues on both sides of the engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED  = 2'd0,
      STATUS_DEADLINE = 2'd1,
      STATUS_BUSY     = 2'd2
   } status_type;

   typedef enum logic {
      ITEM_TICK    = 1'b0,
      ITEM_ACQUIRE = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [WANT_W-1:0] wanted;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic [WAIT_W-1:0] wait_ticks;
   } result_type;

endpackage

FILE: sv/tba_if.sv
`timescale 1ns / 1ps

interface tba_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [tba_pkg::WANT_W-1:0] permits_wanted;

   modport source (output valid, output mode, output permits_wanted, input ready);
   modport sink   (input valid, input mode, input permits_wanted, output ready);
endinterface

interface tba_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tba_pkg::STATUS_W-1:0] status;
   logic [tba_pkg::WAIT_W-1:0]   wait_ticks;

   modport source (output valid, output status, output wait_ticks, input ready);
   modport sink   (input valid, input status, input wait_ticks, output ready);
endinterface

FILE: sv/tba_front.sv
`timescale 1ns / 1ps
`include "token_bucket_acquire_timeout_assert.svh"

module tba_front (
   input  logic              clock,
   input  logic              reset,
   tba_req_if.sink           req_chan,
   output tba_pkg::item_type item_out,
   output logic              item_valid,
   input  logic              item_ready
);

   localparam int PTR_W = tba_pkg::QUEUE_PTR_W;
   localparam int CNT_W = tba_pkg::QUEUE_CNT_W;
   localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(tba_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(tba_pkg::QUEUE_DEPTH - 1);

   tba_pkg::item_type slot_ff [tba_pkg::QUEUE_DEPTH];
   tba_pkg::item_type slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              push, pop;

   assign req_chan.ready = (count_ff != QUEUE_FULL);
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign pop            = item_valid && item_ready;
   assign item_out       = slot_ff[rd_ptr_ff];

   // classify: tick beats carry no permit amount
   always_comb begin
      slot_in.kind   = req_chan.mode ? tba_pkg::ITEM_ACQUIRE : tba_pkg::ITEM_TICK;
      slot_in.wanted = req_chan.mode ? req_chan.permits_wanted : '0;
   end

   always_comb begin
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   `TBA_ASSERT(a_front_no_overrun, push |-> count_ff != QUEUE_FULL, "front queue overrun")
   `TBA_ASSERT(a_front_count_step, pop && !push |=> count_ff == $past(count_ff) - 1'b1, "front count slip")

endmodule

FILE: sv/tba_back.sv
`timescale 1ns / 1ps
`include "token_bucket_acquire_timeout_assert.svh"

module tba_back #(
   parameter int COUNT_BITS = tba_pkg::COUNT_BITS_DEF,
   parameter int FRAC_BITS  = tba_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tba_pkg::CFG_W-1:0]       csr_wr_data,
   input  tba_pkg::item_type               item_in,
   input  logic                            item_valid,
   output logic                            item_ready,
   tba_rsp_if.source                       rsp_chan
);

   localparam int CFG_W  = tba_pkg::CFG_W;
   localparam int WAIT_W = tba_pkg::WAIT_W;
   localparam int WANT_W = tba_pkg::WANT_W;
   localparam int FRAC_W = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int SUM_W  = CFG_W + 1;
   localparam int GROW_W = ((COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W) + 1;
   localparam logic [FRAC_W-1:0] FRAC_MASK   = (FRAC_BITS > 0) ? '1 : '0;
   localparam logic [GROW_W-1:0] COUNT_MAX_G = (GROW_W'(1) << COUNT_BITS) - GROW_W'(1);

   localparam int PTR_W = tba_pkg::QUEUE_PTR_W;
   localparam int CNT_W = tba_pkg::QUEUE_CNT_W;
   localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(tba_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(tba_pkg::QUEUE_DEPTH - 1);

   // configuration
   logic [CFG_W-1:0]      fill_ff, timeout_ff;

   // bucket state
   logic [COUNT_BITS-1:0] permit_ff, permit_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic                  pending_ff, pending_in;
   logic [WANT_W-1:0]     amount_ff, amount_in;
   logic [WAIT_W-1:0]     waited_ff, waited_in;

   // refill path
   logic [SUM_W-1:0]      sum, whole;
   logic [FRAC_W-1:0]     frac_next;
   logic [GROW_W-1:0]     grown;
   logic [COUNT_BITS-1:0] refilled;
   logic [WAIT_W-1:0]     waited_inc;
   logic                  timed_out, enough_refill, enough_now;

   logic                  fire;
   logic                  res_push;
   tba_pkg::result_type   res;

   // result queue
   tba_pkg::result_type   oq_slot_ff [tba_pkg::QUEUE_DEPTH];
   logic [CNT_W-1:0]      oq_count_ff, oq_count_in;
   logic [PTR_W-1:0]      oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic                  oq_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= tba_pkg::FILL_RESET;
         timeout_ff <= tba_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tba_pkg::CSR_FILL_PER_TICK: fill_ff    <= csr_wr_data;
            tba_pkg::CSR_TIMEOUT_TICKS: timeout_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sum        = {1'b0, fill_ff} + SUM_W'(frac_ff);
      whole      = sum >> FRAC_BITS;
      frac_next  = FRAC_W'(sum) & FRAC_MASK;
      grown      = GROW_W'(permit_ff) + GROW_W'(whole);
      refilled   = (grown >= COUNT_MAX_G) ? '1 : COUNT_BITS'(grown);
      waited_inc = (waited_ff != '1) ? waited_ff + WAIT_W'(1) : waited_ff;
      timed_out     = (waited_inc >= timeout_ff);
      enough_refill = (refilled >= COUNT_BITS'(amount_ff));
      enough_now    = (permit_ff >= COUNT_BITS'(item_in.wanted));
   end

   assign item_ready = (oq_count_ff != QUEUE_FULL);
   assign fire       = item_valid && item_ready;

   always_comb begin
      permit_in      = permit_ff;
      frac_in        = frac_ff;
      pending_in     = pending_ff;
      amount_in      = amount_ff;
      waited_in      = waited_ff;
      res_push       = 1'b0;
      res.status     = tba_pkg::STATUS_GRANTED;
      res.wait_ticks = '0;
      if (fire) begin
         unique case (item_in.kind)
            tba_pkg::ITEM_TICK: begin
               permit_in = refilled;
               frac_in   = frac_next;
               if (pending_ff) begin
                  waited_in = waited_inc;
                  priority if (timed_out) begin
                     pending_in     = 1'b0;
                     res_push       = 1'b1;
                     res.status     = tba_pkg::STATUS_DEADLINE;
                     res.wait_ticks = waited_inc;
                  end else if (enough_refill) begin
                     permit_in      = refilled - COUNT_BITS'(amount_ff);
                     pending_in     = 1'b0;
                     res_push       = 1'b1;
                     res.status     = tba_pkg::STATUS_GRANTED;
                     res.wait_ticks = waited_inc;
                  end else begin
                  end
               end
            end
            tba_pkg::ITEM_ACQUIRE: begin
               priority if (pending_ff) begin
                  res_push   = 1'b1;
                  res.status = tba_pkg::STATUS_BUSY;
               end else if (enough_now) begin
                  permit_in  = permit_ff - COUNT_BITS'(item_in.wanted);
                  res_push   = 1'b1;
                  res.status = tba_pkg::STATUS_GRANTED;
               end else begin
                  pending_in = 1'b1;
                  amount_in  = item_in.wanted;
                  waited_in  = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         permit_ff  <= '0;
         frac_ff    <= '0;
         pending_ff <= 1'b0;
         amount_ff  <= '0;
         waited_ff  <= '0;
      end else begin
         permit_ff  <= permit_in;
         frac_ff    <= frac_in;
         pending_ff <= pending_in;
         amount_ff  <= amount_in;
         waited_ff  <= waited_in;
      end
   end

   assign rsp_chan.valid      = (oq_count_ff != '0);
   assign oq_pop              = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.status     = oq_slot_ff[oq_rd_ff].status;
   assign rsp_chan.wait_ticks = oq_slot_ff[oq_rd_ff].wait_ticks;

   always_comb begin
      oq_count_in = oq_count_ff + CNT_W'(res_push) - CNT_W'(oq_pop);
      oq_wr_in    = oq_wr_ff;
      oq_rd_in    = oq_rd_ff;
      if (res_push) begin
         oq_wr_in = (oq_wr_ff == PTR_LAST) ? '0 : oq_wr_ff + PTR_W'(1);
      end
      if (oq_pop) begin
         oq_rd_in = (oq_rd_ff == PTR_LAST) ? '0 : oq_rd_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_count_ff <= '0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
      end else begin
         oq_count_ff <= oq_count_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         oq_slot_ff[oq_wr_ff] <= res;
      end
   end

   `TBA_ASSERT(a_back_no_overrun, res_push |-> oq_count_ff != QUEUE_FULL, "result queue overrun")
   `TBA_ASSERT(a_back_busy_holds, fire && item_in.kind == tba_pkg::ITEM_ACQUIRE && pending_ff |=> pending_ff && amount_ff == $past(amount_ff), "busy beat disturbed pending acquire")
   `TBA_ASSERT(a_back_acquire_no_gain, fire && item_in.kind == tba_pkg::ITEM_ACQUIRE |=> permit_ff <= $past(permit_ff), "acquire raised permit count")

endmodule

FILE: sv/token_bucket_acquire_timeout.sv
`timescale 1ns / 1ps

// token bucket limiter with a blocking acquire and a tick deadline. each beat on
// req_chan is either one time tick (mode 0) or an acquire for permits_wanted
// permits (mode 1). a tick adds fill_per_tick, fixed point with FRAC_BITS
// fraction bits, keeping the fraction, and saturates the count at
// 2^COUNT_BITS - 1; a waiting acquire then times out once its waited ticks reach
// timeout_ticks, or is granted if enough permits are there. results on rsp_chan:
// status 0 granted, 1 deadline exceeded, 2 busy (an acquire while one waits),
// with the ticks waited. ticks that end nothing and acquires that start waiting
// give no result. the block takes one beat every cycle while rsp_chan takes its results;
// a beat's result, if any, passes through the two-entry input queue, then the
// update of the bucket engine, into the two-entry result queue.
// configuration is written through csr_wr_en / csr_index / csr_wr_data
// (index 0 fill_per_tick, reset 65536; index 1 timeout_ticks, reset 1000) and
// should only be changed while the block is idle.

module token_bucket_acquire_timeout #(
   parameter int COUNT_BITS = tba_pkg::COUNT_BITS_DEF,
   parameter int FRAC_BITS  = tba_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   tba_req_if.sink                       req_chan,
   tba_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [tba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tba_pkg::CFG_W-1:0]     csr_wr_data
);

   // classified beats from the front queue to the engine
   tba_pkg::item_type item;
   logic              item_valid;
   logic              item_ready;

   // front: accepts beats, tags tick or acquire, buffers two
   tba_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_out   (item),
      .item_valid (item_valid),
      .item_ready (item_ready)
   );

   // back: bucket engine, configuration and result queue
   tba_back #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .item_in     (item),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule
